>>> hw/rtl/b64d_pkg.sv
// Shared types, constants and the character lookup of the base64 stream decoder.
// No dependencies; the front, queue, back and top files use it by scoped names.
package b64d_pkg;

    // Job queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Item kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters with a special meaning.
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_PAD = 8'h3D;

    localparam logic [15:0] MAX_OUT_RESET = 16'd4095;

    // One unit of work for the back part: up to three bytes of a group,
    // optionally followed by the end-of-string beat.
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  nbytes;
        logic        eos;
        logic [15:0] length;
    } t_job;

    // Alphabet lookup; characters outside the alphabet decode as zero.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        begin
            v = '0;
            if (c >= 8'h41 && c <= 8'h5A) begin
                v = 6'(c - 8'h41);
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                v = 6'(c - 8'h61 + 8'd26);
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = 6'(c - 8'h30 + 8'd52);
            end else if (c == 8'h2B) begin
                v = 6'd62;
            end else if (c == 8'h2F) begin
                v = 6'd63;
            end
            return v;
        end
    endfunction

endpackage

>>> hw/rtl/b64d_if.sv
// Valid/ready channel interfaces for the base64 stream decoder.
// Depends on nothing; used by the front, back and top-level modules.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_char;

    modport source (output valid, output kind, output text_char, input ready);
    modport sink   (input valid, input kind, input text_char, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        run_last;
    logic        string_done;
    logic [15:0] decoded_length;

    modport source (output valid, output data_byte, output has_byte, output run_last,
                    output string_done, output decoded_length, input ready);
    modport sink   (input valid, input data_byte, input has_byte, input run_last,
                    input string_done, input decoded_length, output ready);
endinterface

>>> hw/rtl/b64d_front.sv
// Front part: accepts characters, tracks the group, the limit and the halt state,
// and pushes jobs into the queue. Depends on b64d_pkg and b64d_if.
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    b64d_in_if.sink        i_in,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_full,
    output logic           o_push,
    output b64d_pkg::t_job o_job
);

    logic [15:0] r_max_out;
    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_gp, n_gp;
    logic [2:0]  r_vc, n_vc;
    logic [15:0] r_bytes_out, n_bytes_out;
    logic        r_halted, n_halted;

    logic        accept;
    logic        is_end;
    logic        skip;
    logic        is_pad;
    logic [5:0]  v;
    logic [2:0]  vc_inc;
    logic [16:0] diff;
    logic [1:0]  room;
    logic [1:0]  want;
    logic [1:0]  nemit;
    logic [23:0] triple;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign is_end     = (i_in.kind == b64d_pkg::KIND_END);
    assign skip       = r_halted || i_in.text_char == b64d_pkg::CH_CR
                        || i_in.text_char == b64d_pkg::CH_LF
                        || i_in.text_char == b64d_pkg::CH_SP;
    assign is_pad     = (i_in.text_char == b64d_pkg::CH_PAD);
    assign v          = is_pad ? 6'd0 : b64d_pkg::sextet_of(i_in.text_char);
    assign vc_inc     = r_vc + {2'b00, !is_pad};

    // Bytes still allowed under the limit, clamped to one group's worth.
    assign diff = {1'b0, r_max_out} - {1'b0, r_bytes_out};
    assign room = diff[16] ? 2'd0 : ((diff[15:0] >= 16'd3) ? 2'd3 : diff[1:0]);

    always_comb begin
        n_acc       = r_acc;
        n_gp        = r_gp;
        n_vc        = r_vc;
        n_bytes_out = r_bytes_out;
        n_halted    = r_halted;
        want        = 2'd0;
        triple      = '0;
        if (accept) begin
            if (!is_end) begin
                if (!skip) begin
                    if (r_gp != 2'd3) begin
                        n_acc = {r_acc[11:0], v};
                        n_gp  = r_gp + 2'd1;
                        n_vc  = vc_inc;
                    end else begin
                        triple = {r_acc, v};
                        n_acc  = '0;
                        n_gp   = '0;
                        n_vc   = '0;
                        if (vc_inc < 3'd2) begin
                            n_halted = 1'b1;
                        end else begin
                            want = 2'(vc_inc - 3'd1);
                        end
                    end
                end
            end else begin
                // Flush a partial group with the missing positions as zero.
                if (!r_halted && r_gp != 2'd0 && r_vc >= 3'd2) begin
                    want = 2'(r_vc - 3'd1);
                    case (r_gp)
                        2'd1:    triple = {r_acc[5:0], 18'd0};
                        2'd2:    triple = {r_acc[11:0], 12'd0};
                        2'd3:    triple = {r_acc, 6'd0};
                        default: triple = '0;
                    endcase
                end
                n_acc    = '0;
                n_gp     = '0;
                n_vc     = '0;
                n_halted = 1'b0;
            end
        end
        nemit = (want < room) ? want : room;
        if (accept) begin
            n_bytes_out = is_end ? 16'd0 : (r_bytes_out + {14'd0, nemit});
        end
    end

    assign o_push        = accept && (nemit != 2'd0 || is_end);
    assign o_job.triple  = triple;
    assign o_job.nbytes  = nemit;
    assign o_job.eos     = is_end;
    assign o_job.length  = r_bytes_out + {14'd0, nemit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out   <= b64d_pkg::MAX_OUT_RESET;
            r_acc       <= '0;
            r_gp        <= '0;
            r_vc        <= '0;
            r_bytes_out <= '0;
            r_halted    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_out <= i_cfg_data;
            end
            r_acc       <= n_acc;
            r_gp        <= n_gp;
            r_vc        <= n_vc;
            r_bytes_out <= n_bytes_out;
            r_halted    <= n_halted;
        end
    end

`ifndef SYNTH
    // A halted string never holds a partially filled group.
    a_halt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_gp == 2'd0 && r_vc == 3'd0))
        else $error("halted with a non-empty group");
`endif

endmodule

>>> hw/rtl/b64d_fifo.sv
// Short job queue between the front and back parts of the decoder.
// Depends on b64d_pkg for the job type and depth.
module b64d_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output b64d_pkg::t_job o_head
);

    b64d_pkg::t_job                 r_mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QAW-1:0]       r_wr;
    logic [b64d_pkg::QAW-1:0]       r_rd;
    logic [b64d_pkg::QCW-1:0]       r_count;

    assign o_full       = (r_count == b64d_pkg::QCW'(b64d_pkg::QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + b64d_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + b64d_pkg::QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + b64d_pkg::QCW'(1);
                2'b01:   r_count <= r_count - b64d_pkg::QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");
`endif

endmodule

>>> hw/rtl/b64d_back.sv
// Back part: expands each queued job into output beats through a registered stage.
// Depends on b64d_pkg and b64d_if.
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  b64d_pkg::t_job i_head,
    output logic           o_pop,
    b64d_out_if.source     o_out
);

    logic [1:0]  r_beat;
    logic        r_valid;
    logic [7:0]  r_data;
    logic        r_has;
    logic        r_last;
    logic        r_done;
    logic [15:0] r_len;

    logic        load;
    logic        is_byte;
    logic        last;
    logic [7:0]  sel_byte;

    assign load    = i_head_valid && (!r_valid || o_out.ready);
    assign is_byte = (r_beat < i_head.nbytes);
    assign last    = i_head.eos ? !is_byte : (r_beat == i_head.nbytes - 2'd1);
    assign o_pop   = load && last;

    always_comb begin
        case (r_beat)
            2'd0:    sel_byte = i_head.triple[23:16];
            2'd1:    sel_byte = i_head.triple[15:8];
            default: sel_byte = i_head.triple[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_beat  <= last ? 2'd0 : r_beat + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= is_byte ? sel_byte : 8'd0;
            r_has  <= is_byte;
            r_last <= last;
            r_done <= !is_byte;
            r_len  <= is_byte ? 16'd0 : i_head.length;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.data_byte      = r_data;
    assign o_out.has_byte       = r_has;
    assign o_out.run_last       = r_last;
    assign o_out.string_done    = r_done;
    assign o_out.decoded_length = r_len;

`ifndef SYNTH
    // The beat counter never runs past the beats of the job at the head.
    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_beat <= i_head.nbytes))
        else $error("beat counter beyond job");
    // An end-of-string beat carries no byte and closes its input item.
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> (!r_has && r_last))
        else $error("malformed end-of-string beat");
`endif

endmodule

>>> hw/rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front part, job queue and back part.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_fifo and b64d_back.
//
// The input channel i_in carries one beat per character (kind 0) or one
// end-of-string beat (kind 1). Carriage return, line feed and space are
// skipped; every fourth counted position completes a group that yields up
// to three bytes. The output channel o_out carries one beat per decoded
// byte, and each end-of-string beat yields a final beat with string_done
// set and decoded_length holding the bytes emitted for that string.
// run_last marks the last output beat caused by one input beat.
//
// The front part takes one input beat per cycle while the four-entry job
// queue has room. The back part drains one job at a time, emitting one
// output beat per cycle while the receiver is ready; the first output beat
// of an input beat is written into a queue entry and then loaded into the
// output register. Sustained throughput is one input beat per cycle as
// long as each produces at most one output beat and the receiver stays
// ready; the output side sets the pace otherwise.
// When the receiver stalls, the output register holds its beat, the queue
// fills and i_in.ready drops once it is full. Synchronous reset clears the
// group state, the queue and the output register, and sets the byte limit
// (i_cfg_data written by i_cfg_we) back to 4095.
module base64_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64d_in_if.sink     i_in,
    b64d_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;
    b64d_pkg::t_job job;
    b64d_pkg::t_job head;

    // Classification, group assembly and limit bookkeeping.
    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job)
    );

    // Decouples character intake from multi-beat output.
    b64d_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Serializes each job into byte beats and the end-of-string beat.
    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
